### rtl/crf_pkg.sv
// shared types, constants and helpers of the clipped rectangle fill engine
package crf_pkg;

  localparam int COORD_W = 16;
  localparam int DIM_W = 13;
  localparam int PIX_W = 12;
  localparam int ADDR_W = 32;
  localparam int COLOR_W = 24;
  localparam int PROD_W = 24;
  localparam int LIN_W = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
  localparam logic [DIM_W-1:0] RESET_WIDTH = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  localparam int ITEM_Q_DEPTH = 4;
  localparam int ITEM_Q_AW = 2;
  localparam int RES_Q_DEPTH = 8;
  localparam int RES_Q_AW = 3;

  localparam int NUM_SEG = 4;
  localparam int SEG_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 2'd2;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_FILL = 2'd1;
  localparam logic [1:0] FUNC_OUTLINE = 2'd2;

  typedef enum logic {
    ITEM_TICK,
    ITEM_START
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic outline;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] thick;
    logic [COLOR_W-1:0] color;
  } item_t;

  typedef struct packed {
    logic write;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [ADDR_W-1:0] base;
  } frame_cfg_t;

  typedef struct packed {
    logic wv;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic [ADDR_W-1:0] addr;
    logic [COLOR_W-1:0] color;
    logic last;
    logic busy;
  } result_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage

### rtl/crf_front.sv
// front end: accepts input transactions and classifies them for the item queue
module crf_front (
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  func,
  input  logic [crf_pkg::COORD_W-1:0] x_origin,
  input  logic [crf_pkg::COORD_W-1:0] y_origin,
  input  logic [crf_pkg::COORD_W-1:0] box_width,
  input  logic [crf_pkg::COORD_W-1:0] box_height,
  input  logic [crf_pkg::COORD_W-1:0] edge_thickness,
  input  logic [crf_pkg::COLOR_W-1:0] color_in,
  input  logic                        q_full,
  output logic                        enq,
  output crf_pkg::item_t              enq_item
);

  logic [crf_pkg::COORD_W:0] thick2;
  logic                      too_thick;

  assign full = q_full;
  assign thick2 = {edge_thickness, 1'b0};
  assign too_thick = (thick2 >= {1'b0, box_width}) || (thick2 >= {1'b0, box_height});

  always_comb begin
    enq = push && !q_full &&
          (func inside {crf_pkg::FUNC_TICK, crf_pkg::FUNC_FILL, crf_pkg::FUNC_OUTLINE});
    enq_item.kind = (func == crf_pkg::FUNC_TICK) ? crf_pkg::ITEM_TICK : crf_pkg::ITEM_START;
    enq_item.outline = (func == crf_pkg::FUNC_OUTLINE) && !too_thick;
    enq_item.x = x_origin;
    enq_item.y = y_origin;
    enq_item.w = box_width;
    enq_item.h = box_height;
    enq_item.thick = edge_thickness;
    enq_item.color = color_in;
  end

endmodule

### rtl/crf_item_queue.sv
// short queue of classified items between the front end and the back end
module crf_item_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           enq,
  input  crf_pkg::item_t enq_item,
  output logic           full,
  input  logic           deq,
  output logic           head_valid,
  output crf_pkg::item_t head
);

  crf_pkg::item_t                mem [crf_pkg::ITEM_Q_DEPTH];
  logic [crf_pkg::ITEM_Q_AW:0]   wr_ptr;
  logic [crf_pkg::ITEM_Q_AW:0]   rd_ptr;
  logic [crf_pkg::ITEM_Q_AW:0]   fill;

  assign fill = wr_ptr - rd_ptr;
  assign full = (fill == (crf_pkg::ITEM_Q_AW + 1)'(crf_pkg::ITEM_Q_DEPTH));
  assign head_valid = (wr_ptr != rd_ptr);
  assign head = mem[rd_ptr[crf_pkg::ITEM_Q_AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr[crf_pkg::ITEM_Q_AW-1:0]] <= enq_item;
    end
  end

endmodule

### rtl/crf_back.sv
// back end: bar clipping, pixel walk and address pipeline
module crf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  crf_pkg::frame_cfg_t  cfg,
  input  logic                 head_valid,
  input  crf_pkg::item_t       head,
  output logic                 deq,
  input  logic                 res_pop,
  output logic                 res_push,
  output crf_pkg::result_t     res_data
);

  // latched command
  logic                        outline_mode;
  logic [crf_pkg::COORD_W-1:0] box_x;
  logic [crf_pkg::COORD_W-1:0] box_y;
  logic [crf_pkg::COORD_W-1:0] box_w;
  logic [crf_pkg::COORD_W-1:0] box_h;
  logic [crf_pkg::COORD_W-1:0] box_t;
  logic [crf_pkg::COLOR_W-1:0] saved_color;

  // walk state
  logic                        busy_flag;
  logic [crf_pkg::SEG_W-1:0]   segment_index;
  logic [crf_pkg::PIX_W-1:0]   cursor_x;
  logic [crf_pkg::PIX_W-1:0]   cursor_y;
  logic [crf_pkg::PIX_W-1:0]   span_left;
  logic [crf_pkg::DIM_W-1:0]   span_right;
  logic [crf_pkg::DIM_W-1:0]   span_bottom;

  // clipped bars
  logic [crf_pkg::PIX_W-1:0]   seg_left   [crf_pkg::NUM_SEG];
  logic [crf_pkg::PIX_W-1:0]   seg_top    [crf_pkg::NUM_SEG];
  logic [crf_pkg::DIM_W-1:0]   seg_right  [crf_pkg::NUM_SEG];
  logic [crf_pkg::DIM_W-1:0]   seg_bottom [crf_pkg::NUM_SEG];
  logic [crf_pkg::NUM_SEG-1:0] seg_ok;

  // clip sequencer
  logic                        prep_run;
  logic [crf_pkg::SEG_W:0]     prep_cnt;
  logic                        enter_pending;
  logic                        a_valid;
  logic [crf_pkg::SEG_W-1:0]   a_seg;
  logic [crf_pkg::COORD_W:0]   a_x;
  logic [crf_pkg::COORD_W:0]   a_y;
  logic [crf_pkg::COORD_W:0]   a_w;
  logic [crf_pkg::COORD_W:0]   a_h;
  logic [crf_pkg::COORD_W:0]   a_x_next;
  logic [crf_pkg::COORD_W:0]   a_y_next;
  logic [crf_pkg::COORD_W:0]   a_w_next;
  logic [crf_pkg::COORD_W:0]   a_h_next;

  logic [crf_pkg::COORD_W:0]   x17;
  logic [crf_pkg::COORD_W:0]   y17;
  logic [crf_pkg::COORD_W:0]   w17;
  logic [crf_pkg::COORD_W:0]   h17;
  logic [crf_pkg::COORD_W:0]   t17;
  logic [crf_pkg::COORD_W:0]   mid_h;

  logic [crf_pkg::COORD_W+1:0] clip_rx;
  logic [crf_pkg::COORD_W+1:0] clip_by;
  logic                        clip_ok;
  logic [crf_pkg::DIM_W-1:0]   clip_right;
  logic [crf_pkg::DIM_W-1:0]   clip_bottom;

  // result pipeline
  logic [crf_pkg::RES_Q_AW:0]  reserved;
  logic                        e_valid;
  crf_pkg::result_t            e_res;
  logic [crf_pkg::PROD_W-1:0]  e_prod;
  logic                        f_valid;
  crf_pkg::result_t            f_res;
  logic [crf_pkg::LIN_W-1:0]   f_lin3;
  logic [crf_pkg::LIN_W-1:0]   lin;
  logic [2*crf_pkg::DIM_W-2:0] prod_full;

  // walk control
  logic                        items_ok;
  logic                        credit_ok;
  logic                        take_start;
  logic                        take_tick;
  logic                        restart;
  logic [crf_pkg::SEG_W:0]     seek_from;
  logic                        found;
  logic [crf_pkg::SEG_W-1:0]   found_seg;
  logic [crf_pkg::DIM_W-1:0]   cx_inc;
  logic [crf_pkg::DIM_W-1:0]   cy_inc;
  logic                        row_end;
  logic                        seg_end;
  logic                        busy_after;

  assign items_ok = !prep_run && !enter_pending;
  assign credit_ok = (reserved < (crf_pkg::RES_Q_AW + 1)'(crf_pkg::RES_Q_DEPTH));
  assign take_start = head_valid && items_ok && (head.kind == crf_pkg::ITEM_START);
  assign take_tick = head_valid && items_ok && (head.kind == crf_pkg::ITEM_TICK) && credit_ok;
  assign deq = take_start || take_tick;
  assign restart = take_start || cfg.write;

  // bar geometry of the segment being issued
  assign x17 = {1'b0, box_x};
  assign y17 = {1'b0, box_y};
  assign w17 = {1'b0, box_w};
  assign h17 = {1'b0, box_h};
  assign t17 = {1'b0, box_t};
  assign mid_h = h17 - {box_t, 1'b0};

  always_comb begin
    a_x_next = x17;
    a_y_next = y17;
    a_w_next = w17;
    a_h_next = outline_mode ? t17 : h17;
    case (prep_cnt[crf_pkg::SEG_W-1:0])
      2'd0: begin
        a_x_next = x17;
      end
      2'd1: begin
        a_y_next = y17 + h17 - t17;
        a_h_next = t17;
      end
      2'd2: begin
        a_y_next = y17 + t17;
        a_w_next = t17;
        a_h_next = mid_h;
      end
      2'd3: begin
        a_x_next = x17 + w17 - t17;
        a_y_next = y17 + t17;
        a_w_next = t17;
        a_h_next = mid_h;
      end
      default: begin
        a_x_next = x17;
      end
    endcase
    if (!outline_mode && (prep_cnt[crf_pkg::SEG_W-1:0] != '0)) begin
      a_w_next = '0;
    end
  end

  // clip against the frame
  assign clip_rx = {1'b0, a_x} + {1'b0, a_w};
  assign clip_by = {1'b0, a_y} + {1'b0, a_h};
  assign clip_ok = (a_x < {4'b0, cfg.eff_w}) && (a_y < {4'b0, cfg.eff_h}) &&
                   (a_w != '0) && (a_h != '0);
  assign clip_right = (clip_rx > {5'b0, cfg.eff_w}) ? cfg.eff_w : clip_rx[crf_pkg::DIM_W-1:0];
  assign clip_bottom = (clip_by > {5'b0, cfg.eff_h}) ? cfg.eff_h : clip_by[crf_pkg::DIM_W-1:0];

  // next nonempty bar
  assign seek_from = enter_pending ? '0 : ({1'b0, segment_index} + 1'b1);

  always_comb begin
    found = 1'b0;
    found_seg = '0;
    for (int i = crf_pkg::NUM_SEG - 1; i >= 0; i--) begin
      if (seg_ok[i] && ((crf_pkg::SEG_W + 1)'(i) >= seek_from)) begin
        found = 1'b1;
        found_seg = crf_pkg::SEG_W'(i);
      end
    end
  end

  assign cx_inc = {1'b0, cursor_x} + 1'b1;
  assign cy_inc = {1'b0, cursor_y} + 1'b1;
  assign row_end = (cx_inc >= span_right);
  assign seg_end = row_end && (cy_inc >= span_bottom);
  assign busy_after = busy_flag && (!seg_end || found);

  assign prod_full = {{crf_pkg::DIM_W{1'b0}}, cursor_y} *
                     {{crf_pkg::PIX_W{1'b0}}, cfg.eff_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_run <= 1'b0;
      prep_cnt <= '0;
      enter_pending <= 1'b0;
      a_valid <= 1'b0;
      seg_ok <= '0;
      busy_flag <= 1'b0;
      segment_index <= '0;
    end else begin
      if (restart) begin
        prep_run <= 1'b1;
        prep_cnt <= '0;
        a_valid <= 1'b0;
      end else if (prep_run) begin
        a_valid <= !prep_cnt[crf_pkg::SEG_W];
        if (!prep_cnt[crf_pkg::SEG_W]) begin
          prep_cnt <= prep_cnt + 1'b1;
        end
        if (a_valid && (a_seg == crf_pkg::SEG_W'(crf_pkg::NUM_SEG - 1))) begin
          prep_run <= 1'b0;
        end
      end
      if (a_valid && !restart) begin
        seg_ok[a_seg] <= clip_ok;
      end

      if (take_start) begin
        enter_pending <= 1'b1;
        busy_flag <= 1'b0;
        segment_index <= '0;
      end else if (enter_pending && !prep_run) begin
        enter_pending <= 1'b0;
        busy_flag <= found;
        segment_index <= found ? found_seg : '0;
      end else if (take_tick && busy_flag && seg_end) begin
        busy_flag <= found;
        segment_index <= found ? found_seg : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      a_seg <= '0;
    end else if (prep_run && !prep_cnt[crf_pkg::SEG_W]) begin
      a_seg <= prep_cnt[crf_pkg::SEG_W-1:0];
      a_x <= a_x_next;
      a_y <= a_y_next;
      a_w <= a_w_next;
      a_h <= a_h_next;
    end
    if (a_valid) begin
      seg_left[a_seg] <= a_x[crf_pkg::PIX_W-1:0];
      seg_top[a_seg] <= a_y[crf_pkg::PIX_W-1:0];
      seg_right[a_seg] <= clip_right;
      seg_bottom[a_seg] <= clip_bottom;
    end
    if (take_start) begin
      outline_mode <= head.outline;
      box_x <= head.x;
      box_y <= head.y;
      box_w <= head.w;
      box_h <= head.h;
      box_t <= head.thick;
      saved_color <= head.color;
    end
    if ((enter_pending && !prep_run && !take_start) ||
        (take_tick && busy_flag && seg_end)) begin
      span_left <= seg_left[found_seg];
      span_right <= seg_right[found_seg];
      span_bottom <= seg_bottom[found_seg];
      cursor_x <= seg_left[found_seg];
      cursor_y <= seg_top[found_seg];
    end else if (take_tick && busy_flag) begin
      if (!row_end) begin
        cursor_x <= cx_inc[crf_pkg::PIX_W-1:0];
      end else begin
        cursor_x <= span_left;
        cursor_y <= cy_inc[crf_pkg::PIX_W-1:0];
      end
    end
  end

  // result pipeline: multiply, add x, scale by three, add base
  assign lin = {2'b0, e_prod} + {{(crf_pkg::LIN_W-crf_pkg::PIX_W){1'b0}}, e_res.px};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      reserved <= '0;
    end else begin
      e_valid <= take_tick;
      f_valid <= e_valid;
      if (take_tick && !res_pop) begin
        reserved <= reserved + 1'b1;
      end else if (!take_tick && res_pop) begin
        reserved <= reserved - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_res.wv <= busy_flag;
    e_res.px <= busy_flag ? cursor_x : '0;
    e_res.py <= busy_flag ? cursor_y : '0;
    e_res.addr <= '0;
    e_res.color <= busy_flag ? saved_color : '0;
    e_res.last <= busy_flag && !busy_after;
    e_res.busy <= busy_after;
    e_prod <= busy_flag ? prod_full[crf_pkg::PROD_W-1:0] : '0;
    f_res <= e_res;
    f_lin3 <= lin + {lin[crf_pkg::LIN_W-2:0], 1'b0};
  end

  always_comb begin
    res_push = f_valid;
    res_data = f_res;
    res_data.addr = f_res.wv ? (cfg.base + {{(crf_pkg::ADDR_W-crf_pkg::LIN_W){1'b0}}, f_lin3})
                             : '0;
  end

endmodule

### rtl/crf_res_queue.sv
// result queue in front of the output port
module crf_res_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crf_pkg::result_t push_data,
  input  logic             pop,
  output logic             empty,
  output crf_pkg::result_t head
);

  crf_pkg::result_t           mem [crf_pkg::RES_Q_DEPTH];
  logic [crf_pkg::RES_Q_AW:0] wr_ptr;
  logic [crf_pkg::RES_Q_AW:0] rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign head = mem[rd_ptr[crf_pkg::RES_Q_AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[crf_pkg::RES_Q_AW-1:0]] <= push_data;
    end
  end

endmodule

### rtl/clipped_rect_fill_engine_top.sv
// top level of the clipped rectangle fill engine
// a tick passes the e and f registers and the result queue to reach the output ports
// throughput: one tick per cycle while result credit lasts and no bar clip runs
// a start command holds the back end through operand load, 4 bar clips and entry
// a register write re-clips the pending bars, holding ticks until the clips finish
// reset: queues empty, engine idle, frame 640 x 480 at base address 0
module clipped_rect_fill_engine_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     func,
  input  logic [crf_pkg::COORD_W-1:0]    x_origin,
  input  logic [crf_pkg::COORD_W-1:0]    y_origin,
  input  logic [crf_pkg::COORD_W-1:0]    box_width,
  input  logic [crf_pkg::COORD_W-1:0]    box_height,
  input  logic [crf_pkg::COORD_W-1:0]    edge_thickness,
  input  logic [crf_pkg::COLOR_W-1:0]    color_in,
  output logic                           empty,
  input  logic                           pop,
  output logic                           write_valid,
  output logic [crf_pkg::PIX_W-1:0]      pixel_x,
  output logic [crf_pkg::PIX_W-1:0]      pixel_y,
  output logic [crf_pkg::ADDR_W-1:0]     write_address,
  output logic [crf_pkg::COLOR_W-1:0]    pixel_color,
  output logic                           last_pixel,
  output logic                           engine_busy,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [crf_pkg::DIM_W-1:0]  frame_width;
  logic [crf_pkg::DIM_W-1:0]  frame_height;
  logic [crf_pkg::ADDR_W-1:0] frame_base;

  logic                 q_full;
  logic                 enq;
  crf_pkg::item_t       enq_item;
  logic                 deq;
  logic                 head_valid;
  crf_pkg::item_t       head;
  crf_pkg::frame_cfg_t  cfg;
  logic                 res_push;
  crf_pkg::result_t     res_data;
  crf_pkg::result_t     res_head;
  logic                 cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= crf_pkg::RESET_WIDTH;
      frame_height <= crf_pkg::RESET_HEIGHT;
      frame_base <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        crf_pkg::CFG_FRAME_WIDTH: begin
          frame_width <= cfg_data[crf_pkg::DIM_W-1:0];
        end
        crf_pkg::CFG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[crf_pkg::DIM_W-1:0];
        end
        crf_pkg::CFG_FRAME_BASE: begin
          frame_base <= cfg_data[crf_pkg::ADDR_W-1:0];
        end
        default: begin
          frame_base <= frame_base;
        end
      endcase
    end
  end

  always_comb begin
    cfg.write = cfg_write;
    cfg.eff_w = crf_pkg::sat_dim(frame_width);
    cfg.eff_h = crf_pkg::sat_dim(frame_height);
    cfg.base = frame_base;
  end

  crf_front u_front (
    .push           (push),
    .full           (full),
    .func           (func),
    .x_origin       (x_origin),
    .y_origin       (y_origin),
    .box_width      (box_width),
    .box_height     (box_height),
    .edge_thickness (edge_thickness),
    .color_in       (color_in),
    .q_full         (q_full),
    .enq            (enq),
    .enq_item       (enq_item)
  );

  crf_item_queue u_item_queue (
    .clk        (clk),
    .rst        (rst),
    .enq        (enq),
    .enq_item   (enq_item),
    .full       (q_full),
    .deq        (deq),
    .head_valid (head_valid),
    .head       (head)
  );

  crf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .deq        (deq),
    .res_pop    (pop && !empty),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  crf_res_queue u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (pop),
    .empty     (empty),
    .head      (res_head)
  );

  assign write_valid = res_head.wv;
  assign pixel_x = res_head.px;
  assign pixel_y = res_head.py;
  assign write_address = res_head.addr;
  assign pixel_color = res_head.color;
  assign last_pixel = res_head.last;
  assign engine_busy = res_head.busy;

endmodule

### rtl/crf_checker.sv
// port-level checks of the fill engine and their binding to the top level
module crf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       empty,
  input logic                       pop,
  input logic                       write_valid,
  input logic [crf_pkg::ADDR_W-1:0] write_address,
  input logic                       last_pixel,
  input logic                       engine_busy
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_idle_tick_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !write_valid) |-> (write_address == '0 && !last_pixel && !engine_busy))
    else $error("idle tick result carries nonzero fields");

  a_last_xor_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && write_valid) |-> (last_pixel != engine_busy))
    else $error("pixel write must be either last or followed by more");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result transaction dropped");

endmodule

bind clipped_rect_fill_engine_top crf_checker u_crf_checker (.*);
